// ===== rtl/core/nth_weekday_of_month_macros.svh =====
// Assertion macros for the checker file of the weekday block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef NTH_WEEKDAY_OF_MONTH_MACROS_SVH
`define NTH_WEEKDAY_OF_MONTH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NWM_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("weekday block: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NWM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("weekday block: next-cycle check failed");

// Condition that must hold in the cycle after reset is applied.
`define NWM_ASSERT_RESET(label, post) \
  label: assert property (@(posedge clk) rst |=> (post)) \
    else $error("weekday block: reset check failed");

`endif

// ===== rtl/core/nwm_pkg.sv =====
// Package for the nth-weekday-of-month block: field widths, schedule codes,
// the inter-stage struct and the small calendar functions. No dependencies.
package nwm_pkg;

  // Field widths.
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int WDAY_W  = 3;
  localparam int SCHED_W = 3;
  localparam int DAY_W   = 5;

  // Schedule codes.
  localparam logic [SCHED_W-1:0] SCHED_FIRST  = 3'd0;
  localparam logic [SCHED_W-1:0] SCHED_FOURTH = 3'd3;
  localparam logic [SCHED_W-1:0] SCHED_TEENTH = 3'd4;
  localparam logic [SCHED_W-1:0] SCHED_LAST   = 3'd5;

  // Weekday code that is folded onto Sunday.
  localparam logic [WDAY_W-1:0] WDAY_ALIAS  = 3'd7;
  localparam logic [WDAY_W-1:0] WDAY_SUNDAY = 3'd0;

  // Calendar constants.
  localparam int YEAR_SHIFT   = 400;
  localparam int TEENTH_FIRST = 13;
  localparam int WEEK_DAYS    = 7;

  // Reciprocals for the constant divisions: yy/100 and y/25.
  localparam int RECIP100    = 5243;
  localparam int RECIP100_SH = 19;
  localparam int RECIP25     = 41944;
  localparam int RECIP25_SH  = 20;

  // Reference weekday and month facts handed from the date unit to the top.
  typedef struct packed {
    logic               valid;
    logic [2:0]         weekday;
    logic [DAY_W-1:0]   month_days;
    logic [WDAY_W-1:0]  target;
    logic [SCHED_W-1:0] schedule;
  } nwm_ref_t;

  // Month offset of Sakamoto's rule; months outside 1..12 give zero.
  function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  // Days in a month; zero marks an invalid month.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                             len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:          len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                     len = 5'd31;
      default:                          len = 5'd0;
    endcase
    return len;
  endfunction

  // Remainder by seven of an 11-bit value: octal digits are summed,
  // since eight is one more than seven.
  function automatic logic [2:0] mod7(input logic [10:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    r  = (s2 >= 4'(WEEK_DAYS)) ? s2 - 4'(WEEK_DAYS) : s2;
    return r[2:0];
  endfunction

endpackage

// ===== rtl/core/nwm_date_unit.sv =====
// Date unit: three pipeline stages that find the month length and the
// weekday of the schedule's reference day. Depends on nwm_pkg.
module nwm_date_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [nwm_pkg::YEAR_W-1:0]   year_value,
  input  logic [nwm_pkg::MONTH_W-1:0]  month_number,
  input  logic [nwm_pkg::WDAY_W-1:0]   target_weekday,
  input  logic [nwm_pkg::SCHED_W-1:0]  schedule_code,
  output nwm_pkg::nwm_ref_t            ref_info
);
  import nwm_pkg::*;

  // Stage 1 registers: shifted year and the two reciprocal products.
  logic               s1_valid;
  logic [YEAR_W-1:0]  s1_year;
  logic [14:0]        s1_yy;
  logic [27:0]        s1_p100;
  logic [29:0]        s1_p25;
  logic [MONTH_W-1:0] s1_month;
  logic [WDAY_W-1:0]  s1_target;
  logic [SCHED_W-1:0] s1_sched;

  // Stage 2 registers: century split, month length and month offset.
  logic               s2_valid;
  logic [7:0]         s2_q;
  logic [6:0]         s2_r;
  logic [DAY_W-1:0]   s2_days;
  logic [2:0]         s2_off;
  logic [WDAY_W-1:0]  s2_target;
  logic [SCHED_W-1:0] s2_sched;

  // Stage 3 registers: reference weekday.
  logic               s3_valid;
  logic [2:0]         s3_weekday;
  logic [DAY_W-1:0]   s3_days;
  logic [WDAY_W-1:0]  s3_target;
  logic [SCHED_W-1:0] s3_sched;

  logic [14:0]        yy_next;
  logic [7:0]         q100;
  logic [14:0]        r100_full;
  logic [9:0]         q25;
  logic [YEAR_W-1:0]  r25_full;
  logic               leap;
  logic [DAY_W-1:0]   ref_day;
  logic [10:0]        wsum;

  // Year shifted by four centuries, one less for January and February.
  always_comb begin
    yy_next = 15'(year_value) + 15'(YEAR_SHIFT);
    if (month_number < 4'd3) begin
      yy_next = yy_next - 15'd1;
    end
  end

  // Century split of the shifted year and leap test of the plain year.
  always_comb begin
    q100      = s1_p100[RECIP100_SH+7:RECIP100_SH];
    r100_full = s1_yy - 15'(q100) * 15'd100;
    q25       = s1_p25[RECIP25_SH+9:RECIP25_SH];
    r25_full  = s1_year - YEAR_W'(q25) * YEAR_W'(25);
    leap      = (s1_year[1:0] == 2'd0) &&
                ((r25_full[4:0] != 5'd0) || (s1_year[3:0] == 4'd0));
  end

  // Reference weekday: 124q (as 5q) + r + r/4 + q/4 + offset + day, mod 7.
  always_comb begin
    if (s2_sched == SCHED_TEENTH) begin
      ref_day = DAY_W'(TEENTH_FIRST);
    end else if (s2_sched == SCHED_LAST) begin
      ref_day = s2_days;
    end else begin
      ref_day = 5'd1;
    end
    wsum = 11'({s2_q, 2'b00}) + 11'(s2_q) + 11'(s2_q[7:2]) + 11'(s2_r) +
           11'(s2_r[6:2]) + 11'(s2_off) + 11'(ref_day);
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Payload of the three stages moves with the valid bits.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_year   <= year_value;
      s1_yy     <= yy_next;
      s1_p100   <= 28'(yy_next) * 28'(RECIP100);
      s1_p25    <= 30'(year_value) * 30'(RECIP25);
      s1_month  <= month_number;
      s1_target <= (target_weekday == WDAY_ALIAS) ? WDAY_SUNDAY : target_weekday;
      s1_sched  <= schedule_code;

      s2_q      <= q100;
      s2_r      <= r100_full[6:0];
      s2_days   <= month_length(s1_month, leap);
      s2_off    <= month_offset(s1_month);
      s2_target <= s1_target;
      s2_sched  <= s1_sched;

      s3_weekday <= mod7(wsum);
      s3_days    <= s2_days;
      s3_target  <= s2_target;
      s3_sched   <= s2_sched;
    end
  end

  assign ref_info.valid      = s3_valid;
  assign ref_info.weekday    = s3_weekday;
  assign ref_info.month_days = s3_days;
  assign ref_info.target     = s3_target;
  assign ref_info.schedule   = s3_sched;

endmodule

// ===== rtl/core/nth_weekday_of_month.sv =====
// Top level of the nth-weekday-of-month block: date unit plus the final
// day selection and output register. Depends on nwm_pkg and nwm_date_unit.
//
// Usage:
// A query item carries year_value, month_number, target_weekday and
// schedule_code on the query channel (query_valid, query_stall). Each item
// gives exactly one result item, day_of_month and found, on the result
// channel (result_valid, result_stall), in order.
// The pipeline has four register stages: two reciprocal products, the
// century split with the month length, the reference weekday, and the day
// selection. An accepted item moves through these stages in that order,
// and one item can be accepted per cycle while query_stall is low.
// All stages advance together; query_stall is high exactly while a result is
// held and the receiver stalls, so a stall freezes the whole pipeline and no
// item is lost or repeated.
// Reset clears every valid bit; the payload registers are not reset.
module nth_weekday_of_month (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         query_valid,
  output logic                         query_stall,
  input  logic [nwm_pkg::YEAR_W-1:0]   year_value,
  input  logic [nwm_pkg::MONTH_W-1:0]  month_number,
  input  logic [nwm_pkg::WDAY_W-1:0]   target_weekday,
  input  logic [nwm_pkg::SCHED_W-1:0]  schedule_code,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [nwm_pkg::DAY_W-1:0]    day_of_month,
  output logic                         found
);
  import nwm_pkg::*;

  logic             en;
  nwm_ref_t         ref_info;
  logic [3:0]       fwd_sum;
  logic [2:0]       fwd_gap;
  logic [3:0]       back_sum;
  logic [2:0]       back_gap;
  logic [5:0]       day_calc;
  logic             day_ok;
  logic [DAY_W-1:0] day_next;

  // The pipeline moves unless a held result is stalled.
  assign en          = !(result_valid && result_stall);
  assign query_stall = !en;

  nwm_date_unit u_date (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (query_valid),
    .year_value     (year_value),
    .month_number   (month_number),
    .target_weekday (target_weekday),
    .schedule_code  (schedule_code),
    .ref_info       (ref_info)
  );

  // Distance forward and backward from the reference day to the target.
  always_comb begin
    fwd_sum  = 4'(ref_info.target) + 4'(WEEK_DAYS) - 4'(ref_info.weekday);
    fwd_gap  = (fwd_sum >= 4'(WEEK_DAYS)) ? 3'(fwd_sum - 4'(WEEK_DAYS)) : fwd_sum[2:0];
    back_sum = 4'(ref_info.weekday) + 4'(WEEK_DAYS) - 4'(ref_info.target);
    back_gap = (back_sum >= 4'(WEEK_DAYS)) ? 3'(back_sum - 4'(WEEK_DAYS)) : back_sum[2:0];
  end

  // Day selection by schedule, then the range check against the month.
  always_comb begin
    if (ref_info.schedule <= SCHED_FOURTH) begin
      day_calc = 6'd1 + 6'(fwd_gap) +
                 6'(ref_info.schedule - SCHED_FIRST) * 6'(WEEK_DAYS);
    end else if (ref_info.schedule == SCHED_TEENTH) begin
      day_calc = 6'(TEENTH_FIRST) + 6'(fwd_gap);
    end else if (ref_info.schedule == SCHED_LAST) begin
      day_calc = 6'(ref_info.month_days) - 6'(back_gap);
    end else begin
      day_calc = 6'd0;
    end
    day_ok   = (ref_info.month_days != 5'd0) && (day_calc != 6'd0) &&
               (day_calc <= 6'(ref_info.month_days));
    day_next = day_ok ? day_calc[DAY_W-1:0] : 5'd0;
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= ref_info.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_of_month <= day_next;
      found        <= day_ok;
    end
  end

endmodule

// ===== rtl/core/nwm_checker.sv =====
// Port-level checker for the nth-weekday-of-month block and its bind.
// Depends on nth_weekday_of_month_macros.svh and the top level's ports.
`include "nth_weekday_of_month_macros.svh"

module nwm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        query_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [nwm_pkg::DAY_W-1:0]   day_of_month,
  input logic                        found
);

  // The result channel is empty right after reset.
  `NWM_ASSERT_RESET(a_reset_empty, !result_valid)

  // Queries are held back only while a result waits on a stalled receiver.
  `NWM_ASSERT_IMPL(a_stall_cause, query_stall, result_valid && result_stall)

  // The found flag agrees with a nonzero day.
  `NWM_ASSERT_IMPL(a_found_day, result_valid, found == (day_of_month != 5'd0))

  // A stalled result item stays on the port unchanged.
  `NWM_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                   result_valid && $stable(day_of_month) && $stable(found))

endmodule

bind nth_weekday_of_month nwm_checker u_nwm_checker (
  .clk          (clk),
  .rst          (rst),
  .query_stall  (query_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .day_of_month (day_of_month),
  .found        (found)
);
